>>> rtl/sgcb_pkg.sv
// shared types, constants and helpers for the sparse graph convolution backward block
package sgcb_pkg;

    localparam int NB_W = 3;
    localparam int NV_W = 9;
    localparam int NF_W = 5;
    localparam int NL_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [2:0] {
        CMD_LOAD_V  = 3'd0,
        CMD_LOAD_G  = 3'd1,
        CMD_LOAD_H  = 3'd2,
        CMD_EDGE    = 3'd3,
        CMD_READ_VG = 3'd4,
        CMD_READ_WG = 3'd5,
        CMD_CLEAR   = 3'd6
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USED_BATCHES      = 3'd0,
        REG_USED_VERTICES     = 3'd1,
        REG_USED_IN_FEATURES  = 3'd2,
        REG_USED_OUT_FEATURES = 3'd3,
        REG_USED_LAYERS       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [NB_W-1:0] nb;
        logic [NV_W-1:0] nv;
        logic [NF_W-1:0] nf1;
        logic [NF_W-1:0] nf2;
        logic [NL_W-1:0] nl;
    } dims_t;

    typedef struct packed {
        logic               ignored;
        cmd_t               cmd;
        logic [1:0]         batch_index;
        logic [7:0]         target_node;
        logic [7:0]         source_node;
        logic [1:0]         layer_index;
        logic [3:0]         in_feature;
        logic [3:0]         out_feature;
        logic signed [15:0] data_value;
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_EDGE,
        ST_DRAIN,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               sat;
    } sat_t;

    function automatic sat_t sat_add64(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [63:0] s;
        sat_t r;
        s = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.value = r.sat ? (a[63] ? ACC_MIN : ACC_MAX) : s;
        return r;
    endfunction

endpackage

>>> rtl/sgcb_front.sv
// front end: range check and classification of requests, small queue to the back end
module sgcb_front
    import sgcb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         command,
    input  logic [1:0]         batch_index,
    input  logic [7:0]         target_node,
    input  logic [7:0]         source_node,
    input  logic [1:0]         layer_index,
    input  logic [3:0]         in_feature,
    input  logic [3:0]         out_feature,
    input  logic signed [15:0] data_value,
    input  dims_t              dims,
    input  logic               init_busy,
    output logic               q_valid,
    input  logic               q_pop,
    output op_t                q_op
);

    op_t        q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       enq;
    logic       b_ok, n1_ok, n2_ok, l_ok, fi_ok, fo_ok;
    op_t        dec;

    always_comb
    begin
        b_ok  = NB_W'(batch_index) < dims.nb;
        n1_ok = NV_W'(target_node) < dims.nv;
        n2_ok = NV_W'(source_node) < dims.nv;
        l_ok  = NL_W'(layer_index) < dims.nl;
        fi_ok = NF_W'(in_feature) < dims.nf1;
        fo_ok = NF_W'(out_feature) < dims.nf2;
        dec.cmd         = cmd_t'(command);
        dec.batch_index = batch_index;
        dec.target_node = target_node;
        dec.source_node = source_node;
        dec.layer_index = layer_index;
        dec.in_feature  = in_feature;
        dec.out_feature = out_feature;
        dec.data_value  = data_value;
        case (cmd_t'(command))
            CMD_LOAD_V:  dec.ignored = !(b_ok && n2_ok && fi_ok);
            CMD_LOAD_G:  dec.ignored = !(b_ok && n1_ok && fo_ok);
            CMD_LOAD_H:  dec.ignored = !(l_ok && fi_ok && fo_ok);
            CMD_EDGE:    dec.ignored = !(b_ok && n1_ok && n2_ok && l_ok);
            CMD_READ_VG: dec.ignored = !(b_ok && n2_ok && fi_ok);
            CMD_READ_WG: dec.ignored = !(l_ok && fi_ok && fo_ok);
            CMD_CLEAR:   dec.ignored = 1'b0;
            default:     dec.ignored = 1'b1;
        endcase
    end

    assign full    = (cnt_reg == 2'd2) || init_busy;
    assign enq     = push && !full;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(enq) - 2'(q_pop && q_valid);
        end
    end

endmodule

>>> rtl/sgcb_back.sv
// back end: stores, accumulators, product pipeline and result slot
module sgcb_back
    import sgcb_pkg::*;
#(
    parameter int MAX_BATCH        = 4,
    parameter int MAX_VERTICES     = 256,
    parameter int MAX_IN_FEATURES  = 16,
    parameter int MAX_OUT_FEATURES = 16,
    parameter int MAX_LAYERS       = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dims_t              dims,
    input  logic               q_valid,
    output logic               q_pop,
    input  op_t                q_op,
    output logic               init_busy,
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] result_value,
    output logic               status,
    output logic               saturated
);

    localparam int VDEPTH    = MAX_BATCH * MAX_VERTICES * MAX_IN_FEATURES;
    localparam int GDEPTH    = MAX_BATCH * MAX_VERTICES * MAX_OUT_FEATURES;
    localparam int HDEPTH    = MAX_LAYERS * MAX_IN_FEATURES * MAX_OUT_FEATURES;
    localparam int VAW       = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int GAW       = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int HAW       = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int CLR_DEPTH = (VDEPTH > HDEPTH) ? VDEPTH : HDEPTH;
    localparam int CLW       = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    logic signed [15:0] v_mem  [VDEPTH];
    logic signed [15:0] g_mem  [GDEPTH];
    logic signed [15:0] h_mem  [HDEPTH];
    logic signed [63:0] vg_mem [VDEPTH];
    logic signed [63:0] wg_mem [HDEPTH];

    back_state_t state_reg, state_next;
    op_t         op_reg;

    logic [NF_W-1:0] f1_cnt_reg, f2_cnt_reg;
    logic [CLW-1:0]  clr_cnt_reg;
    logic [NF_W-1:0] fi_sel, fo_sel;
    logic            f1_last, f2_last, clr_last, clr_sweep;
    logic [VAW-1:0]  v_addr;
    logic [GAW-1:0]  g_addr;
    logic [HAW-1:0]  h_addr;

    logic v_we, g_we, h_we, out_load, issue, pipe_busy;
    logic vg_we, wg_we;
    logic [VAW-1:0] vg_waddr;
    logic [HAW-1:0] wg_waddr;
    logic signed [63:0] vg_wdata, wg_wdata;
    sat_t wg_sum, vg_sum;

    // memory read data
    logic signed [15:0] g_q, h_q, v_q;
    logic signed [63:0] vg_q, wg_q;

    // pipeline registers
    logic               p1_reg, p2_reg, p3_reg, p4_reg;
    logic               first1_reg, last1_reg, first2_reg, last2_reg, first3_reg, last3_reg;
    logic [VAW-1:0]     va1_reg, va2_reg, va3_reg, va4_reg;
    logic [HAW-1:0]     ha1_reg, ha2_reg, ha3_reg;
    logic signed [31:0] gh2_reg, ga2_reg;
    logic signed [15:0] v2_reg;
    logic signed [63:0] wg2_reg, wg3_reg, vg2_reg, vg3_reg, vg4_reg;
    logic signed [47:0] ghv3_reg, gha3_reg, gav3_reg;
    logic signed [63:0] vsum_reg, vsum_next, vsum4_reg;

    logic signed [63:0] acc_reg;
    logic               sat_reg, stat_reg;
    logic               out_valid_reg;
    logic signed [63:0] out_value_reg;
    logic               out_status_reg, out_sat_reg;

    assign fi_sel = (state_reg == ST_EDGE) ? f1_cnt_reg : NF_W'(op_reg.in_feature);
    assign fo_sel = (state_reg == ST_EDGE) ? f2_cnt_reg : NF_W'(op_reg.out_feature);

    assign v_addr = VAW'((32'(op_reg.batch_index) * 32'(MAX_VERTICES)
                          + 32'(op_reg.source_node)) * 32'(MAX_IN_FEATURES) + 32'(fi_sel));
    assign g_addr = GAW'((32'(op_reg.batch_index) * 32'(MAX_VERTICES)
                          + 32'(op_reg.target_node)) * 32'(MAX_OUT_FEATURES) + 32'(fo_sel));
    assign h_addr = HAW'((32'(op_reg.layer_index) * 32'(MAX_IN_FEATURES)
                          + 32'(fi_sel)) * 32'(MAX_OUT_FEATURES) + 32'(fo_sel));

    assign f1_last   = (f1_cnt_reg == dims.nf1 - NF_W'(1));
    assign f2_last   = (f2_cnt_reg == dims.nf2 - NF_W'(1));
    assign clr_last  = (clr_cnt_reg == CLW'(CLR_DEPTH - 1));
    assign clr_sweep = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign issue     = (state_reg == ST_EDGE);
    assign pipe_busy = p1_reg || p2_reg || p3_reg || p4_reg;
    assign init_busy = (state_reg == ST_INIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg.ignored)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (op_reg.cmd)
                        CMD_EDGE:
                        begin
                            if (dims.nf1 == '0 || dims.nf2 == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_EDGE;
                            end
                        end
                        CMD_READ_VG: state_next = ST_RD_WAIT;
                        CMD_READ_WG: state_next = ST_RD_WAIT;
                        CMD_CLEAR:   state_next = ST_CLEAR;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_EDGE:
            begin
                if (f1_last && f2_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_WAIT: state_next = ST_DONE;
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = 1'b0;
        v_we     = 1'b0;
        g_we     = 1'b0;
        h_we     = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop = q_valid;
            ST_EXEC:
            begin
                if (!op_reg.ignored)
                begin
                    case (op_reg.cmd)
                        CMD_LOAD_V: v_we = 1'b1;
                        CMD_LOAD_G: g_we = 1'b1;
                        CMD_LOAD_H: h_we = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_DONE: out_load = !out_valid_reg || pop;
            default: ;
        endcase
    end

    // accumulator write ports
    assign wg_sum = sat_add64(wg3_reg, 64'(gav3_reg));
    assign vg_sum = sat_add64(vg4_reg, vsum4_reg);
    assign vsum_next = (first3_reg ? 64'sd0 : vsum_reg) + 64'(gha3_reg);

    always_comb
    begin
        if (clr_sweep)
        begin
            wg_we    = (32'(clr_cnt_reg) < 32'(HDEPTH));
            wg_waddr = HAW'(clr_cnt_reg);
            wg_wdata = 64'sd0;
            vg_we    = 1'b1;
            vg_waddr = VAW'(clr_cnt_reg);
            vg_wdata = 64'sd0;
        end
        else
        begin
            wg_we    = p3_reg;
            wg_waddr = ha3_reg;
            wg_wdata = wg_sum.value;
            vg_we    = p4_reg;
            vg_waddr = va4_reg;
            vg_wdata = vg_sum.value;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            v_mem[v_addr] <= op_reg.data_value;
        end
        v_q <= v_mem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            g_mem[g_addr] <= op_reg.data_value;
        end
        g_q <= g_mem[g_addr];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_mem[h_addr] <= op_reg.data_value;
        end
        h_q <= h_mem[h_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vg_we)
        begin
            vg_mem[vg_waddr] <= vg_wdata;
        end
        vg_q <= vg_mem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wg_we)
        begin
            wg_mem[wg_waddr] <= wg_wdata;
        end
        wg_q <= wg_mem[h_addr];
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            op_reg <= q_op;
        end
        // issue -> stage 1 addresses and flags
        first1_reg <= (f2_cnt_reg == '0);
        last1_reg  <= f2_last;
        va1_reg    <= v_addr;
        ha1_reg    <= h_addr;
        // stage 1 -> 2: first products
        gh2_reg    <= 32'(g_q) * 32'(h_q);
        ga2_reg    <= 32'(g_q) * 32'(op_reg.data_value);
        v2_reg     <= v_q;
        wg2_reg    <= wg_q;
        vg2_reg    <= vg_q;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        va2_reg    <= va1_reg;
        ha2_reg    <= ha1_reg;
        // stage 2 -> 3: triple products
        ghv3_reg   <= 48'(gh2_reg) * 48'(v2_reg);
        gha3_reg   <= 48'(gh2_reg) * 48'(op_reg.data_value);
        gav3_reg   <= 48'(ga2_reg) * 48'(v2_reg);
        wg3_reg    <= wg2_reg;
        vg3_reg    <= vg2_reg;
        first3_reg <= first2_reg;
        last3_reg  <= last2_reg;
        va3_reg    <= va2_reg;
        ha3_reg    <= ha2_reg;
        // stage 3: running vertex term per input feature
        if (p3_reg)
        begin
            vsum_reg <= vsum_next;
        end
        vsum4_reg <= vsum_next;
        vg4_reg   <= vg3_reg;
        va4_reg   <= va3_reg;

        if (state_reg == ST_EXEC)
        begin
            acc_reg  <= 64'sd0;
            sat_reg  <= 1'b0;
            stat_reg <= op_reg.ignored;
        end
        else if (state_reg == ST_RD_WAIT)
        begin
            acc_reg <= (op_reg.cmd == CMD_READ_VG) ? vg_q : wg_q;
        end
        else
        begin
            if (p3_reg)
            begin
                acc_reg <= acc_reg + 64'(ghv3_reg);
            end
            if ((p3_reg && wg_sum.sat) || (p4_reg && vg_sum.sat))
            begin
                sat_reg <= 1'b1;
            end
        end

        if (out_load)
        begin
            out_value_reg  <= acc_reg;
            out_status_reg <= stat_reg;
            out_sat_reg    <= sat_reg;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            f1_cnt_reg    <= '0;
            f2_cnt_reg    <= '0;
            clr_cnt_reg   <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            p3_reg        <= 1'b0;
            p4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC)
            begin
                f1_cnt_reg  <= '0;
                f2_cnt_reg  <= '0;
                clr_cnt_reg <= '0;
            end
            else if (issue)
            begin
                if (f2_last)
                begin
                    f2_cnt_reg <= '0;
                    f1_cnt_reg <= f1_cnt_reg + NF_W'(1);
                end
                else
                begin
                    f2_cnt_reg <= f2_cnt_reg + NF_W'(1);
                end
            end
            else if (clr_sweep)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + CLW'(1);
            end
            p1_reg <= issue;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg && last3_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;
    assign saturated    = out_sat_reg;

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("product pipeline busy while idle");

    a_load_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (v_we || g_we || h_we) |-> (state_reg == ST_EXEC && !op_reg.ignored))
        else $error("store written outside a load");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("request taken from an empty queue");

    a_sweep_no_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        clr_sweep |-> !pipe_busy)
        else $error("accumulator sweep overlaps edge pipeline");

endmodule

>>> rtl/sparse_graph_conv_backward.sv
// top level of the sparse graph convolution backward block: size registers and front/back hookup
//
// after reset the block zeroes both gradient accumulators, one entry a cycle, across
// max(MAX_BATCH*MAX_VERTICES*MAX_IN_FEATURES, MAX_LAYERS*MAX_IN_FEATURES*MAX_OUT_FEATURES)
// entries (16384 with the default sizes) and holds full high meanwhile; a clear request
// runs the same sweep. requests enter a two-deep queue and are carried out one at a time
// by the back end. a load writes its store in the exec state; a readout waits in a read
// wait state for the stored value. an edge issues one (in feature, out feature) pair per
// cycle through a single four-stage multiply and accumulate pipeline, issuing
// used_in_features*used_out_features pairs and then draining; that pipeline and the
// single read port of each store set the rate. each request gives exactly one result;
// the result slot lets the next request start while an earlier result waits to be popped.
module sparse_graph_conv_backward
    import sgcb_pkg::*;
#(
    parameter int MAX_BATCH        = 4,
    parameter int MAX_VERTICES     = 256,
    parameter int MAX_IN_FEATURES  = 16,
    parameter int MAX_OUT_FEATURES = 16,
    parameter int MAX_LAYERS       = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            command,
    input  logic [1:0]            batch_index,
    input  logic [7:0]            target_node,
    input  logic [7:0]            source_node,
    input  logic [1:0]            layer_index,
    input  logic [3:0]            in_feature,
    input  logic [3:0]            out_feature,
    input  logic signed [15:0]    data_value,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic signed [63:0]    result_value,
    output logic                  status,
    output logic                  saturated,
    // size register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NB_W-1:0] used_batches_reg;
    logic [NV_W-1:0] used_vertices_reg;
    logic [NF_W-1:0] used_in_features_reg;
    logic [NF_W-1:0] used_out_features_reg;
    logic [NL_W-1:0] used_layers_reg;
    dims_t           dims;
    logic            q_valid, q_pop, init_busy;
    op_t             q_op;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_batches_reg      <= NB_W'(1);
            used_vertices_reg     <= NV_W'(256);
            used_in_features_reg  <= NF_W'(16);
            used_out_features_reg <= NF_W'(16);
            used_layers_reg       <= NL_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_USED_BATCHES:      used_batches_reg      <= cfg_data[NB_W-1:0];
                REG_USED_VERTICES:     used_vertices_reg     <= cfg_data[NV_W-1:0];
                REG_USED_IN_FEATURES:  used_in_features_reg  <= cfg_data[NF_W-1:0];
                REG_USED_OUT_FEATURES: used_out_features_reg <= cfg_data[NF_W-1:0];
                REG_USED_LAYERS:       used_layers_reg       <= cfg_data[NL_W-1:0];
                default:               ;
            endcase
        end
    end

    // sizes in use, clamped to what the stores hold
    always_comb
    begin
        dims.nb  = (32'(used_batches_reg) > 32'(MAX_BATCH))
                   ? NB_W'(MAX_BATCH) : used_batches_reg;
        dims.nv  = (32'(used_vertices_reg) > 32'(MAX_VERTICES))
                   ? NV_W'(MAX_VERTICES) : used_vertices_reg;
        dims.nf1 = (32'(used_in_features_reg) > 32'(MAX_IN_FEATURES))
                   ? NF_W'(MAX_IN_FEATURES) : used_in_features_reg;
        dims.nf2 = (32'(used_out_features_reg) > 32'(MAX_OUT_FEATURES))
                   ? NF_W'(MAX_OUT_FEATURES) : used_out_features_reg;
        dims.nl  = (32'(used_layers_reg) > 32'(MAX_LAYERS))
                   ? NL_W'(MAX_LAYERS) : used_layers_reg;
    end

    sgcb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .batch_index (batch_index),
        .target_node (target_node),
        .source_node (source_node),
        .layer_index (layer_index),
        .in_feature  (in_feature),
        .out_feature (out_feature),
        .data_value  (data_value),
        .dims        (dims),
        .init_busy   (init_busy),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_op        (q_op)
    );

    sgcb_back #(
        .MAX_BATCH        (MAX_BATCH),
        .MAX_VERTICES     (MAX_VERTICES),
        .MAX_IN_FEATURES  (MAX_IN_FEATURES),
        .MAX_OUT_FEATURES (MAX_OUT_FEATURES),
        .MAX_LAYERS       (MAX_LAYERS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .init_busy    (init_busy),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .status       (status),
        .saturated    (saturated)
    );

endmodule

>>> dv/sparse_graph_conv_backward_tb.sv
// testbench for the sparse graph convolution backward block: scoreboard, stimulus and checks
module sparse_graph_conv_backward_tb;
    import sgcb_pkg::*;

    // command code with no meaning, must come back ignored
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int END_WAIT = 300;
    localparam int SETTLE_WAIT = 20;

    // one request as it goes onto the pins
    typedef struct {
        logic [2:0]         cmd;
        logic [1:0]         b;
        logic [7:0]         n1;
        logic [7:0]         n2;
        logic [1:0]         l;
        logic [3:0]         fi;
        logic [3:0]         fo;
        logic signed [15:0] d;
    } grad_req_s;

    // one result as the block should return it
    typedef struct {
        longint value;
        bit     ignored;
        bit     sat;
    } grad_res_s;

    class grad_scoreboard;
        logic signed [15:0] vmem[16384];
        logic signed [15:0] gmem[16384];
        logic signed [15:0] hmem[1024];
        bit                 vset[16384];
        bit                 gset[16384];
        bit                 hset[1024];
        longint             vgacc[16384];
        longint             wgacc[1024];
        int unsigned        reg_nb = 1, reg_nv = 256, reg_nf1 = 16, reg_nf2 = 16, reg_nl = 1;
        grad_res_s          pending_q[$];
        int                 errors = 0;

        function int unsigned nb();  return reg_nb  > 4   ? 4   : reg_nb;  endfunction
        function int unsigned nv();  return reg_nv  > 256 ? 256 : reg_nv;  endfunction
        function int unsigned nf1(); return reg_nf1 > 16  ? 16  : reg_nf1; endfunction
        function int unsigned nf2(); return reg_nf2 > 16  ? 16  : reg_nf2; endfunction
        function int unsigned nl();  return reg_nl  > 4   ? 4   : reg_nl;  endfunction

        function int vix(int b, int n, int f); return (b * 256 + n) * 16 + f; endfunction
        function int hix(int l, int f1, int f2); return (l * 16 + f1) * 16 + f2; endfunction

        function void set_reg(cfg_reg_t r, int unsigned v);
            case (r)
                REG_USED_BATCHES:      reg_nb  = v & 7;
                REG_USED_VERTICES:     reg_nv  = v & 511;
                REG_USED_IN_FEATURES:  reg_nf1 = v & 31;
                REG_USED_OUT_FEATURES: reg_nf2 = v & 31;
                REG_USED_LAYERS:       reg_nl  = v & 7;
                default: ;
            endcase
        endfunction

        function bit edge_in_range(int b, int n1, int n2, int l);
            return b < nb() && n1 < nv() && n2 < nv() && l < nl();
        endfunction

        // saturating add at the signed 64-bit limits
        function longint sadd(longint a, longint x, inout bit s);
            logic [64:0] t;
            t = {a[63], a} + {x[63], x};
            if (t[64] != t[63])
            begin
                s = 1;
                return t[64] ? ACC_MIN : ACC_MAX;
            end
            return t[63:0];
        endfunction

        function void note(grad_req_s q);
            grad_res_s r;
            longint vsum, g, h, v, a;
            r.value = 0;
            r.ignored = 0;
            r.sat = 0;
            a = q.d;
            case (q.cmd)
                CMD_LOAD_V:
                    if (q.b < nb() && q.n2 < nv() && q.fi < nf1())
                    begin
                        vmem[vix(q.b, q.n2, q.fi)] = q.d;
                        vset[vix(q.b, q.n2, q.fi)] = 1;
                    end
                    else r.ignored = 1;
                CMD_LOAD_G:
                    if (q.b < nb() && q.n1 < nv() && q.fo < nf2())
                    begin
                        gmem[vix(q.b, q.n1, q.fo)] = q.d;
                        gset[vix(q.b, q.n1, q.fo)] = 1;
                    end
                    else r.ignored = 1;
                CMD_LOAD_H:
                    if (q.l < nl() && q.fi < nf1() && q.fo < nf2())
                    begin
                        hmem[hix(q.l, q.fi, q.fo)] = q.d;
                        hset[hix(q.l, q.fi, q.fo)] = 1;
                    end
                    else r.ignored = 1;
                CMD_EDGE:
                    if (edge_in_range(q.b, q.n1, q.n2, q.l))
                    begin
                        for (int f1 = 0; f1 < nf1(); f1++)
                        begin
                            v = vmem[vix(q.b, q.n2, f1)];
                            vsum = 0;
                            for (int f2 = 0; f2 < nf2(); f2++)
                            begin
                                g = gmem[vix(q.b, q.n1, f2)];
                                h = hmem[hix(q.l, f1, f2)];
                                r.value += g * h * v;
                                vsum += g * h * a;
                                wgacc[hix(q.l, f1, f2)] =
                                    sadd(wgacc[hix(q.l, f1, f2)], g * a * v, r.sat);
                            end
                            vgacc[vix(q.b, q.n2, f1)] =
                                sadd(vgacc[vix(q.b, q.n2, f1)], vsum, r.sat);
                        end
                    end
                    else r.ignored = 1;
                CMD_READ_VG:
                    if (q.b < nb() && q.n2 < nv() && q.fi < nf1())
                        r.value = vgacc[vix(q.b, q.n2, q.fi)];
                    else r.ignored = 1;
                CMD_READ_WG:
                    if (q.l < nl() && q.fi < nf1() && q.fo < nf2())
                        r.value = wgacc[hix(q.l, q.fi, q.fo)];
                    else r.ignored = 1;
                CMD_CLEAR:
                begin
                    foreach (vgacc[i]) vgacc[i] = 0;
                    foreach (wgacc[i]) wgacc[i] = 0;
                end
                default: r.ignored = 1;
            endcase
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check(longint value, bit ignored, bit sat);
            grad_res_s e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("result %0d with nothing outstanding", value));
                return;
            end
            e = pending_q.pop_front();
            if (value != e.value)
                report($sformatf("result_value %0d, want %0d", value, e.value));
            if (ignored != e.ignored)
                report($sformatf("status %0b, want %0b", ignored, e.ignored));
            if (sat != e.sat)
                report($sformatf("saturated %0b, want %0b", sat, e.sat));
        endtask
    endclass

    logic                  clk = 0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [2:0]            command;
    logic [1:0]            batch_index;
    logic [7:0]            target_node;
    logic [7:0]            source_node;
    logic [1:0]            layer_index;
    logic [3:0]            in_feature;
    logic [3:0]            out_feature;
    logic signed [15:0]    data_value;
    logic                  empty;
    logic                  pop;
    logic signed [63:0]    result_value;
    logic                  status;
    logic                  saturated;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    grad_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    bit  quiet = 0;     // no idling on either side while set
    int  last_b = 0, last_n2 = 0, last_l = 0;

    sparse_graph_conv_backward dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // watchdog, covers the clearing sweep after reset and every clear request
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("sparse_graph_conv_backward_tb failed");
            $finish;
        end
    end

    // result side: check on the rising edge, change pop on the falling edge
    initial
    begin
        pop = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check(result_value, status, saturated);
            @(negedge clk);
            pop <= quiet || $urandom_range(99) >= 18;
        end
    end

    function automatic int pick(int unsigned n);
        return (n == 0) ? 0 : $urandom_range(n - 1);
    endfunction

    // data values lean toward the extremes now and then
    function automatic logic signed [15:0] rand_data();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // one request: random gaps, then hold push until the block takes it
    task automatic send(grad_req_s q);
        while (!quiet && $urandom_range(99) < 18)
        begin
            @(negedge clk);
            push <= 0;
        end
        @(negedge clk);
        push        <= 1;
        command     <= q.cmd;
        batch_index <= q.b;
        target_node <= q.n1;
        source_node <= q.n2;
        layer_index <= q.l;
        in_feature  <= q.fi;
        out_feature <= q.fo;
        data_value  <= q.d;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note(q);
        sent++;
    endtask

    task automatic put(logic [2:0] cmd, int b, int n1, int n2, int l, int fi, int fo,
                       logic signed [15:0] d);
        grad_req_s q;
        q.cmd = cmd;
        q.b = 2'(b);
        q.n1 = 8'(n1);
        q.n2 = 8'(n2);
        q.l = 2'(l);
        q.fi = 4'(fi);
        q.fo = 4'(fo);
        q.d = d;
        send(q);
    endtask

    // an edge preceded by loads of every feature, gradient and weight it reads
    // that has not been written yet
    task automatic put_edge(int b, int n1, int n2, int l, logic signed [15:0] a);
        for (int f1 = 0; f1 < sb.nf1(); f1++)
            if (!sb.vset[sb.vix(b, n2, f1)])
                put(CMD_LOAD_V, b, pick(256), n2, pick(4), f1, pick(16), rand_data());
        for (int f2 = 0; f2 < sb.nf2(); f2++)
            if (!sb.gset[sb.vix(b, n1, f2)])
                put(CMD_LOAD_G, b, n1, pick(256), pick(4), pick(16), f2, rand_data());
        for (int f1 = 0; f1 < sb.nf1(); f1++)
            for (int f2 = 0; f2 < sb.nf2(); f2++)
                if (!sb.hset[sb.hix(l, f1, f2)])
                    put(CMD_LOAD_H, pick(4), pick(256), pick(256), l, f1, f2, rand_data());
        put(CMD_EDGE, b, n1, n2, l, pick(16), pick(16), a);
        last_b = b;
        last_n2 = n2;
        last_l = l;
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        push <= 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, int unsigned v);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= r;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(r, v);
    endtask

    task automatic set_sizes(int unsigned b, int unsigned v, int unsigned f1,
                             int unsigned f2, int unsigned l);
        write_reg(REG_USED_BATCHES, b);
        write_reg(REG_USED_VERTICES, v);
        write_reg(REG_USED_IN_FEATURES, f1);
        write_reg(REG_USED_OUT_FEATURES, f2);
        write_reg(REG_USED_LAYERS, l);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // one random request or well-formed edge sequence
    task automatic random_step();
        grad_req_s q;
        int sel;
        bit sized;
        sized = sb.nb() && sb.nv() && sb.nf1() && sb.nf2() && sb.nl();
        sel = $urandom_range(99);
        if ($urandom_range(199) == 0)
            put(CMD_CLEAR, pick(4), pick(256), pick(256), pick(4), pick(16), pick(16),
                rand_data());
        else if (sized && sel < 45)
            put_edge(pick(sb.nb()), pick(sb.nv()), pick(sb.nv()), pick(sb.nl()), rand_data());
        else if (sized && sel < 55)
            put(3'($urandom_range(2)), pick(sb.nb()), pick(sb.nv()), pick(sb.nv()),
                pick(sb.nl()), pick(sb.nf1()), pick(sb.nf2()), rand_data());
        else if (sized && sel < 66)
        begin
            // half of the vertex gradient reads go where the last edge landed
            if ($urandom_range(1))
                put(CMD_READ_VG, last_b, pick(256), last_n2, pick(4), pick(sb.nf1()),
                    pick(16), rand_data());
            else
                put(CMD_READ_VG, pick(sb.nb()), pick(256), pick(sb.nv()), pick(4),
                    pick(sb.nf1()), pick(16), rand_data());
        end
        else if (sized && sel < 77)
            put(CMD_READ_WG, pick(4), pick(256), pick(256), $urandom_range(1) ? last_l :
                pick(sb.nl()), pick(sb.nf1()), pick(sb.nf2()), rand_data());
        else
        begin
            // noise over the whole field range, mostly out of range
            q.cmd = 3'($urandom_range(7));
            q.b = 2'($urandom_range(3));
            q.n1 = 8'($urandom_range(255));
            q.n2 = 8'($urandom_range(255));
            q.l = 2'($urandom_range(3));
            q.fi = 4'($urandom_range(15));
            q.fo = 4'($urandom_range(15));
            q.d = rand_data();
            if (q.cmd == CMD_CLEAR)
                q.cmd = CMD_UNKNOWN;
            if (q.cmd == CMD_EDGE && sb.edge_in_range(q.b, q.n1, q.n2, q.l))
                put_edge(q.b, q.n1, q.n2, q.l, q.d);
            else
                send(q);
        end
    endtask

    task automatic random_run(int n, int quiet_from, int quiet_to);
        int start;
        start = sent;
        while (sent - start < n)
        begin
            quiet = (sent - start) >= quiet_from && (sent - start) < quiet_to;
            random_step();
        end
        quiet = 0;
        settle();
    endtask

    initial
    begin
        rst_n       = 0;
        push        = 0;
        command     = CMD_LOAD_V;
        batch_index = 0;
        target_node = 0;
        source_node = 0;
        layer_index = 0;
        in_feature  = 0;
        out_feature = 0;
        data_value  = 0;
        cfg_valid   = 0;
        cfg_index   = REG_USED_BATCHES;
        cfg_data    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset sizes: a read of a zeroed accumulator and a batch that is not in use
        put(CMD_READ_WG, 0, 0, 0, 0, 15, 15, 0);
        put(CMD_LOAD_V, 1, 0, 0, 0, 0, 0, 16'sh0100);
        settle();

        // full sizes: loads and reads at the corners of every field
        set_sizes(4, 256, 16, 16, 4);
        put(CMD_LOAD_V, 3, 0, 255, 0, 15, 0, 16'sh7FFF);
        put(CMD_LOAD_V, 0, 255, 0, 3, 0, 15, 16'sh8000);
        put(CMD_LOAD_G, 3, 255, 0, 0, 0, 15, 16'sh8000);
        put(CMD_LOAD_H, 0, 0, 0, 3, 15, 15, 16'sh7FFF);
        put(CMD_READ_VG, 3, 0, 255, 0, 15, 0, 0);
        put(CMD_READ_WG, 0, 0, 0, 3, 15, 15, 0);
        put(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        put(CMD_UNKNOWN, 3, 255, 255, 3, 15, 15, 16'sh7FFF);
        settle();

        // one of each: the most negative values everywhere, then out of range items
        set_sizes(1, 2, 1, 1, 1);
        put(CMD_LOAD_V, 0, 0, 1, 0, 0, 0, 16'sh8000);
        put(CMD_LOAD_G, 0, 1, 0, 0, 0, 0, 16'sh8000);
        put(CMD_LOAD_H, 0, 0, 0, 0, 0, 0, 16'sh8000);
        put(CMD_EDGE, 0, 1, 1, 0, 0, 0, 16'sh8000);
        put(CMD_EDGE, 0, 1, 1, 0, 0, 0, 16'sh7FFF);
        put(CMD_READ_VG, 0, 0, 1, 0, 0, 0, 0);
        put(CMD_READ_WG, 0, 0, 0, 0, 0, 0, 0);
        put(CMD_EDGE, 1, 0, 0, 0, 0, 0, 16'sh0100);
        put(CMD_EDGE, 0, 2, 0, 0, 0, 0, 16'sh0100);
        put(CMD_EDGE, 0, 0, 0, 1, 0, 0, 16'sh0100);
        put(CMD_LOAD_V, 0, 0, 0, 0, 1, 0, 16'sh0100);
        put(CMD_LOAD_G, 0, 0, 0, 0, 0, 1, 16'sh0100);
        put(CMD_READ_WG, 0, 0, 0, 0, 0, 1, 0);
        settle();

        random_step();
        random_run(300, 80, 200);

        set_sizes(2, 8, 3, 2, 2);
        random_run(450, 150, 400);

        // a pause mid-run until everything is back, then more of the same
        set_sizes(4, 256, 4, 4, 4);
        random_run(250, 1000, 1000);
        random_run(250, 0, 0);

        // zero sizes: everything but a clear is ignored
        set_sizes(0, 0, 0, 0, 0);
        random_run(40, 0, 0);

        // values above the parameter limits are clamped
        set_sizes(7, 511, 31, 31, 7);
        random_run(120, 0, 0);

        set_sizes(3, 100, 5, 7, 3);
        random_run(400, 0, 0);

        settle();
        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("sparse_graph_conv_backward_tb passed");
        else
            $display("sparse_graph_conv_backward_tb failed");
        $finish;
    end

endmodule
